### rtl/pulse_period_capture_meter_core_assert.svh
// assertion macros for the pulse period capture meter checker
`ifndef PULSE_PERIOD_CAPTURE_METER_CORE_ASSERT_SVH
`define PULSE_PERIOD_CAPTURE_METER_CORE_ASSERT_SVH

// implication checked in the next cycle, ignored while reset is high
`define PPCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppcm check failed");

// implication checked in the next cycle, also checked across reset
`define PPCM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ppcm check failed");

`endif

### rtl/ppcm_pkg.sv
// shared types and constants of the pulse period capture meter
package ppcm_pkg;

   localparam int RELOAD_W   = 16;
   localparam int LAP_W      = RELOAD_W + 1;
   localparam int RATE_W     = 27;
   localparam int TICK_W     = 32;
   localparam int SCALE_W    = 20;
   localparam int NUM_W      = TICK_W + SCALE_W;
   localparam int DIV_STEPS  = NUM_W / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [SCALE_W-1:0]  US_PER_SEC    = SCALE_W'(1000000);
   localparam logic [RELOAD_W-1:0] RELOAD_RESET  = '1;
   localparam logic [RATE_W-1:0]   RATE_RESET    = RATE_W'(1000000);
   localparam logic [CNT_W-1:0]    DIV_LAST      = CNT_W'(DIV_STEPS - 1);

   typedef enum logic [1:0] {
      OP_OVERFLOW = 2'd0,
      OP_CAPTURE  = 2'd1,
      OP_START    = 2'd2,
      OP_STOP     = 2'd3
   } op_type;

   typedef enum logic {
      KIND_PERIOD = 1'b0,
      KIND_HIGH   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RELOAD    = 2'd0,
      CSR_TICK_RATE = 2'd1,
      CSR_COUNT_OVF = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SCALE,
      ST_DIV,
      ST_OUT
   } state_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [RELOAD_W-1:0] reload;
      logic [RATE_W-1:0]   tick_rate;
      logic                count_ovf;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic mul;
      logic add;
      logic scale;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
      logic out_busy;
   } dp_sts_type;

endpackage

### rtl/ppcm_csr.sv
// configuration register file with apb-style access
module ppcm_csr
   import ppcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [RELOAD_W-1:0] reload_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic                covf_ff;
   logic                wr_en;
   csr_idx_type         idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_idx_type'(csr_paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= RELOAD_RESET;
         rate_ff   <= RATE_RESET;
         covf_ff   <= 1'b1;
      end else if (wr_en) begin
         case (idx)
            CSR_RELOAD:    reload_ff <= csr_pwdata[RELOAD_W-1:0];
            CSR_TICK_RATE: rate_ff   <= csr_pwdata[RATE_W-1:0];
            CSR_COUNT_OVF: covf_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         CSR_RELOAD:    csr_prdata = {{(32-RELOAD_W){1'b0}}, reload_ff};
         CSR_TICK_RATE: csr_prdata = {{(32-RATE_W){1'b0}}, rate_ff};
         CSR_COUNT_OVF: csr_prdata = {31'b0, covf_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.reload    = reload_ff;
   assign cfg.tick_rate = rate_ff;
   assign cfg.count_ovf = covf_ff;

endmodule

### rtl/ppcm_ctrl.sv
// sequencer for one measurement: multiply, add, scale, divide, output
module ppcm_ctrl
   import ppcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && sts.emit) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_SCALE;
         ST_SCALE: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_MUL:   cmd.mul      = 1'b1;
         ST_ADD:   cmd.add      = 1'b1;
         ST_SCALE: cmd.scale    = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_OUT:   cmd.load_out = !sts.out_busy;
         default: ;
      endcase
   end

endmodule

### rtl/ppcm_dp.sv
// edge tracking state, tick arithmetic, radix-4 divider and output register
module ppcm_dp
   import ppcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic [1:0]          req_tuser,
   input  logic [RELOAD_W-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic                rsp_tuser
);

   op_type              op;
   logic                running_ff, expf_ff, have_rise_ff;
   logic [RELOAD_W-1:0] rise_cap_ff;
   logic [TICK_W-1:0]   laps_rise_ff, laps_edge_ff;

   logic                kind_ff;
   logic [TICK_W-1:0]   laps_op_ff, diff_ff, ticks_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [RATE_W-1:0]   rem_ff;
   logic [TICK_W-1:0]   quo_ff;

   logic                out_valid_ff, out_kind_ff;
   logic [TICK_W-1:0]   out_ticks_ff, out_us_ff;

   logic [LAP_W-1:0]    lap_len;
   logic [TICK_W+LAP_W-1:0] prod_full;
   logic [NUM_W-1:0]    scale_full;
   logic [RATE_W:0]     r1, r2, dv;
   logic                ge1, ge2;
   logic [RATE_W-1:0]   d1, d2;

   assign op = op_type'(req_tuser);

   assign sts.emit     = (op == OP_CAPTURE) && running_ff && (expf_ff || have_rise_ff);
   assign sts.out_busy = out_valid_ff && !rsp_tready;

   // edge tracking state, updated as each word is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         expf_ff      <= 1'b0;
         have_rise_ff <= 1'b0;
         rise_cap_ff  <= '0;
         laps_rise_ff <= '0;
         laps_edge_ff <= '0;
      end else if (cmd.accept) begin
         case (op)
            OP_OVERFLOW: begin
               if (running_ff && cfg.count_ovf) begin
                  laps_rise_ff <= laps_rise_ff + 1'b1;
                  laps_edge_ff <= laps_edge_ff + 1'b1;
               end
            end
            OP_CAPTURE: begin
               if (running_ff) begin
                  laps_edge_ff <= '0;
                  expf_ff      <= !expf_ff;
                  if (!expf_ff) begin
                     rise_cap_ff  <= req_tdata;
                     have_rise_ff <= 1'b1;
                     laps_rise_ff <= '0;
                  end
               end
            end
            OP_START: begin
               laps_rise_ff <= '0;
               laps_edge_ff <= '0;
               expf_ff      <= 1'b0;
               running_ff   <= 1'b1;
            end
            default: begin
               running_ff <= 1'b0;
               expf_ff    <= 1'b0;
            end
         endcase
      end
   end

   // operand capture, span uses the rise capture from before this edge
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= expf_ff ? KIND_HIGH : KIND_PERIOD;
         laps_op_ff <= expf_ff ? laps_edge_ff : laps_rise_ff;
         diff_ff    <= {{(TICK_W-RELOAD_W){1'b0}}, req_tdata}
                     - {{(TICK_W-RELOAD_W){1'b0}}, rise_cap_ff};
      end
   end

   // laps times lap length, then add the capture difference
   assign lap_len   = {1'b0, cfg.reload} + 1'b1;
   assign prod_full = laps_op_ff * lap_len;
   assign scale_full = ticks_ff * US_PER_SEC;

   // two restoring divide steps per cycle
   assign dv = {1'b0, cfg.tick_rate};
   assign r1  = {rem_ff, num_ff[NUM_W-1]};
   assign ge1 = (r1 >= dv);
   assign d1  = ge1 ? RATE_W'(r1 - dv) : r1[RATE_W-1:0];
   assign r2  = {d1, num_ff[NUM_W-2]};
   assign ge2 = (r2 >= dv);
   assign d2  = ge2 ? RATE_W'(r2 - dv) : r2[RATE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         ticks_ff <= prod_full[TICK_W-1:0];
      end else if (cmd.add) begin
         ticks_ff <= ticks_ff + diff_ff;
      end
      if (cmd.scale) begin
         num_ff <= scale_full;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-3:0], 2'b00};
         rem_ff <= d2;
         quo_ff <= {quo_ff[TICK_W-3:0], ge1, ge2};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_kind_ff  <= kind_ff;
         out_ticks_ff <= ticks_ff;
         out_us_ff    <= (cfg.tick_rate == '0) ? '0 : quo_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {out_us_ff, out_ticks_ff};

endmodule

### rtl/pulse_period_capture_meter_core.sv
// pulse period capture meter: top level
//
//   group   dir  handshake              contents
//   req_    in   req_tvalid/req_tready  tuser: op[1:0]; tdata: capture_value[15:0]
//   rsp_    out  rsp_tvalid/rsp_tready  tuser: kind; tdata: ticks[31:0], us[63:32]
//   csr_    in   psel/penable/pready    three registers at byte addresses 0, 4, 8
//
// overflow, start, stop and ignored edges leave the sequencer idle and ready for the next word.
// an edge that gives a result holds off requests through multiply, add, scale by 1e6 and a
// two-bit-per-cycle divider, then waits while the output register still holds an untaken word.
// a finished word sits in the output register while the next word is taken.
// reset is synchronous and returns the configuration and control registers to their defaults.
module pulse_period_capture_meter_core
   import ppcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // capture_value[15:0]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // elapsed_ticks[31:0], elapsed_us[63:32]
   output logic        rsp_tuser,   // kind[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // configuration registers
   ppcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   ppcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   ppcm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/ppcm_checker.sv
// port-level checks for the pulse period capture meter
`include "pulse_period_capture_meter_core_assert.svh"

module ppcm_checker
   import ppcm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic        req_acc;
   logic        non_edge;
   logic        rsp_stall;
   logic [64:0] rsp_word;

   assign req_acc   = req_tvalid && req_tready;
   assign non_edge  = (req_tuser != OP_CAPTURE);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // no result word right after reset
   `PPCM_ASSERT_NEXT_ALWAYS(a_rst_empty, clock, reset, !rsp_tvalid)

   // a stalled result word holds
   `PPCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // overflow, start and stop leave the block ready in the next cycle
   `PPCM_ASSERT_NEXT(a_short_op, clock, reset, req_acc && non_edge, req_tready)

   // overflow, start and stop never make a result
   `PPCM_ASSERT_NEXT(a_no_result, clock, reset, req_acc && non_edge && !rsp_tvalid, !rsp_tvalid)

endmodule

bind pulse_period_capture_meter_core ppcm_checker u_ppcm_checker (.*);

### test/tb.sv
// testbench for the pulse period capture meter: directed table, random pulse trains, scoreboard
module tb;
   import ppcm_pkg::*;

   localparam int RANDOM_ITEMS   = 1850;
   localparam int PHASE_ITEMS    = 240;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   // one measurement as it leaves the block
   typedef struct packed {
      kind_type    kind;
      logic [31:0] ticks;
      logic [31:0] us;
   } capture_result_type;

   // one line of the directed table: a register write or a word
   typedef struct packed {
      bit                 is_csr;
      csr_idx_type        reg_idx;
      logic [31:0]        wr_value;
      op_type             op;
      logic [15:0]        cap;
      bit                 typed;
      capture_result_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // capture_value[15:0]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // elapsed_ticks[31:0], elapsed_us[63:32]
   logic        rsp_tuser;   // kind[0]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // hand-typed expectation that travels beside the word being offered
   bit                 drv_typed;
   capture_result_type drv_exp;

   // register copies
   logic [15:0] reload_cfg = 16'hFFFF;
   logic [26:0] rate_cfg   = 27'd1000000;
   logic        ovf_cfg    = 1'b1;

   // measurement state
   bit          run_on     = 1'b0;
   bit          await_fall = 1'b0;
   bit          rise_seen  = 1'b0;
   logic [15:0] rise_cap   = '0;
   logic [31:0] laps_rise  = '0;
   logic [31:0] laps_edge  = '0;

   capture_result_type pending_measurements[$];
   plan_row_type       plan[$];
   int                 failures        = 0;
   int                 effective_words = 0;
   int                 stall_cycles    = 0;
   int                 burst_left      = 0;
   bit                 long_hold_req   = 1'b0;

   pulse_period_capture_meter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ticks from the rise capture to this capture, modulo 2^32
   function automatic logic [31:0] lap_span(input logic [31:0] laps, input logic [15:0] cap);
      return laps * (32'(reload_cfg) + 32'd1) + 32'(cap) - 32'(rise_cap);
   endfunction

   function automatic logic [31:0] ticks_to_us(input logic [31:0] ticks);
      logic [63:0] scaled;
      scaled = 64'(ticks) * 64'd1000000;
      if (rate_cfg == '0) return '0;
      return 32'(scaled / 64'(rate_cfg));
   endfunction

   // advance the measurement state by one word, report any measurement it yields
   function automatic void measure_event(input op_type op, input logic [15:0] cap,
                                         output bit fired,
                                         output capture_result_type res);
      fired   = 1'b0;
      res     = '0;
      case (op)
         OP_OVERFLOW: begin
            if (run_on && ovf_cfg) begin
               laps_rise++;
               laps_edge++;
            end
         end
         OP_CAPTURE: begin
            if (!run_on) begin
               fired = 1'b0;
            end else if (!await_fall) begin
               // rising edge: period only once an earlier rise exists
               if (rise_seen) begin
                  res.kind  = KIND_PERIOD;
                  res.ticks = lap_span(laps_rise, cap);
                  res.us    = ticks_to_us(res.ticks);
                  fired     = 1'b1;
               end
               rise_cap   = cap;
               rise_seen  = 1'b1;
               laps_rise  = '0;
               laps_edge  = '0;
               await_fall = 1'b1;
            end else begin
               res.kind   = KIND_HIGH;
               res.ticks  = lap_span(laps_edge, cap);
               res.us     = ticks_to_us(res.ticks);
               fired      = 1'b1;
               laps_edge  = '0;
               await_fall = 1'b0;
            end
         end
         OP_START: begin
            laps_rise  = '0;
            laps_edge  = '0;
            await_fall = 1'b0;
            run_on     = 1'b1;
         end
         default: begin
            run_on     = 1'b0;
            await_fall = 1'b0;
         end
      endcase
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // compare one result word with the oldest pending measurement
   task automatic check_result(input logic kind_bit, input logic [63:0] data);
      capture_result_type want;
      if (pending_measurements.size() == 0) begin
         note_failure($sformatf("unexpected word: kind %0d ticks %0d us %0d",
                                kind_bit, data[31:0], data[63:32]));
         return;
      end
      want = pending_measurements.pop_front();
      if (want.kind !== kind_bit || want.ticks !== data[31:0] || want.us !== data[63:32])
         note_failure($sformatf("mismatch: expected kind %0d ticks %0d us %0d, %s",
                                want.kind, want.ticks, want.us,
                                $sformatf("got kind %0d ticks %0d us %0d",
                                          kind_bit, data[31:0], data[63:32])));
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      bit                 fired;
      bit                 moved;
      capture_result_type got;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tuser, rsp_tdata);
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            measure_event(op_type'(req_tuser), req_tdata, fired, got);
            if (drv_typed) pending_measurements.push_back(drv_exp);
            else if (fired) pending_measurements.push_back(got);
            effective_words++;
            moved = 1'b1;
         end
         if (csr_psel && csr_penable && csr_pready) moved = 1'b1;
         if (moved) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   // watchdog on cycles with no transfer anywhere
   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // result side stall pattern, with one long hold on request
   initial begin : rsp_stalls
      int mode;
      int run_len;
      rsp_tready = 1'b0;
      forever begin
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(1, 60);
         repeat (run_len) begin
            @(negedge clock);
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 9) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // offer one word in bursts with random gaps, return once it is taken
   task automatic put_word(input op_type op, input logic [15:0] cap, input bit typed,
                           input capture_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= cap;
      drv_typed  <= typed;
      drv_exp    <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, let every pending measurement drain and the block go idle
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_measurements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup then access
   task automatic write_csr(input csr_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_RELOAD:    reload_cfg = value[15:0];
         CSR_TICK_RATE: rate_cfg   = value[26:0];
         CSR_COUNT_OVF: ovf_cfg    = value[0];
         default: ;
      endcase
   endtask

   function automatic plan_row_type word_row(input op_type op, input logic [15:0] cap);
      plan_row_type r;
      r    = '0;
      r.op = op;
      r.cap = cap;
      return r;
   endfunction

   function automatic plan_row_type result_row(input op_type op, input logic [15:0] cap,
                                               input kind_type kind,
                                               input logic [31:0] ticks,
                                               input logic [31:0] us);
      plan_row_type r;
      r            = '0;
      r.op         = op;
      r.cap        = cap;
      r.typed      = 1'b1;
      r.want.kind  = kind;
      r.want.ticks = ticks;
      r.want.us    = us;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input csr_idx_type idx, input logic [31:0] value);
      plan_row_type r;
      r          = '0;
      r.is_csr   = 1'b1;
      r.reg_idx  = idx;
      r.wr_value = value;
      return r;
   endfunction

   // main stimulus
   initial begin : stimulus
      int                 phase;
      int                 phase_end;
      int                 n_edges;
      int                 n_ovf;
      capture_result_type none;
      none        = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_OVERFLOW;
      drv_typed   = 1'b0;
      drv_exp     = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // directed table, starting from the reset settings
      // edges and overflows while stopped are ignored
      plan.push_back(word_row(OP_CAPTURE, 16'h1234));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(word_row(OP_START, 16'h0000));
      // first rise gives nothing
      plan.push_back(word_row(OP_CAPTURE, 16'h0000));
      plan.push_back(result_row(OP_CAPTURE, 16'hFFFF, KIND_HIGH, 32'd65535, 32'd65535));
      plan.push_back(result_row(OP_CAPTURE, 16'h0000, KIND_PERIOD, 32'd0, 32'd0));
      plan.push_back(word_row(OP_OVERFLOW, 16'hFFFF));
      plan.push_back(result_row(OP_CAPTURE, 16'h0000, KIND_HIGH, 32'd65536, 32'd65536));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      // period keeps its own lap count across the falling edge
      plan.push_back(result_row(OP_CAPTURE, 16'hFFFF, KIND_PERIOD, 32'd262143, 32'd262143));
      // capture below the rise wraps modulo 2^32
      plan.push_back(result_row(OP_CAPTURE, 16'h0000, KIND_HIGH, 32'hFFFF0001, 32'hFFFF0001));
      plan.push_back(word_row(OP_STOP, 16'h0000));
      plan.push_back(word_row(OP_CAPTURE, 16'h5555));
      // restart keeps the earlier rise
      plan.push_back(word_row(OP_START, 16'hFFFF));
      plan.push_back(word_row(OP_CAPTURE, 16'hAAAA));
      // start while running drops the pending falling edge
      plan.push_back(word_row(OP_START, 16'h0000));
      plan.push_back(word_row(OP_CAPTURE, 16'h7FFF));
      plan.push_back(word_row(OP_CAPTURE, 16'h8000));
      // overflow counting off
      plan.push_back(csr_row(CSR_COUNT_OVF, 32'd0));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(word_row(OP_CAPTURE, 16'h0001));
      // one-tick lap and zero tick rate
      plan.push_back(csr_row(CSR_RELOAD, 32'd0));
      plan.push_back(csr_row(CSR_COUNT_OVF, 32'd1));
      plan.push_back(csr_row(CSR_TICK_RATE, 32'd0));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(result_row(OP_CAPTURE, 16'h0000, KIND_HIGH, 32'd1, 32'd0));
      // slowest and fastest tick rate
      plan.push_back(csr_row(CSR_TICK_RATE, 32'd1));
      plan.push_back(csr_row(CSR_RELOAD, 32'd65535));
      plan.push_back(word_row(OP_CAPTURE, 16'hFFFF));
      plan.push_back(csr_row(CSR_TICK_RATE, 32'd72000000));
      plan.push_back(word_row(OP_OVERFLOW, 16'h0000));
      plan.push_back(word_row(OP_CAPTURE, 16'h8000));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle_block();
            write_csr(plan[i].reg_idx, plan[i].wr_value);
         end else begin
            put_word(plan[i].op, plan[i].cap, plan[i].typed, plan[i].want);
         end
      end

      // random phases, each under its own register settings
      phase = 0;
      effective_words = 0;
      while (effective_words < RANDOM_ITEMS) begin
         settle_block();
         case ($urandom_range(0, 3))
            0: write_csr(CSR_RELOAD, 32'd0);
            1: write_csr(CSR_RELOAD, 32'd65535);
            2: write_csr(CSR_RELOAD, $urandom_range(0, 65535));
            default: write_csr(CSR_RELOAD, $urandom_range(0, 15));
         endcase
         case ($urandom_range(0, 3))
            0: write_csr(CSR_TICK_RATE, 32'd1);
            1: write_csr(CSR_TICK_RATE, 32'd72000000);
            2: write_csr(CSR_TICK_RATE, 32'd1000000);
            default: write_csr(CSR_TICK_RATE, $urandom_range(1, 72000000));
         endcase
         write_csr(CSR_COUNT_OVF, 32'($urandom_range(0, 3) != 0));
         // fill the block while results are held off
         if (phase == 1) long_hold_req = 1'b1;
         phase_end = effective_words + PHASE_ITEMS;
         while (effective_words < phase_end) begin
            if ($urandom_range(0, 4) != 0) begin
               // well-formed pulse train with random captures and laps
               n_edges = $urandom_range(2, 12);
               if ($urandom_range(0, 4) != 0)
                  put_word(OP_START, 16'($urandom_range(0, 65535)), 1'b0, none);
               repeat (n_edges) begin
                  n_ovf = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                  repeat (n_ovf) put_word(OP_OVERFLOW, 16'($urandom_range(0, 65535)), 1'b0, none);
                  put_word(OP_CAPTURE, 16'($urandom_range(0, 65535)), 1'b0, none);
               end
               if ($urandom_range(0, 3) == 0)
                  put_word(OP_STOP, 16'($urandom_range(0, 65535)), 1'b0, none);
            end else begin
               // noise: any op, any value
               repeat ($urandom_range(1, 5))
                  put_word(op_type'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), 1'b0,
                           none);
            end
         end
         phase++;
      end

      // drain and finish
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_measurements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_measurements.size() != 0)
         note_failure($sformatf("%0d measurements never arrived", pending_measurements.size()));
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
